/* hdl/iopd_pkg.sv */
// ----------------------------------------------------------------------------
// I/O instruction port decoder package
// Opcode and prefix bytes, size codes and the decode result type.
// ----------------------------------------------------------------------------
package iopd_pkg;

  localparam int unsigned PortW   = 16;
  localparam int unsigned LimitW  = 17;
  localparam int unsigned SizeW   = 5;

  localparam logic [LimitW-1:0] PORT_LIMIT_RST = 17'h10000;
  localparam int unsigned WHOLE_SPACE_CODE_DFLT = 16;

  localparam logic [7:0] OP_IN_B_DX    = 8'hec;
  localparam logic [7:0] OP_IN_D_DX    = 8'hed;
  localparam logic [7:0] OP_OUT_B_DX   = 8'hee;
  localparam logic [7:0] OP_OUT_D_DX   = 8'hef;
  localparam logic [7:0] OP_INS_B      = 8'h6c;
  localparam logic [7:0] OP_INS_D      = 8'h6d;
  localparam logic [7:0] OP_OUTS_B     = 8'h6e;
  localparam logic [7:0] OP_OUTS_D     = 8'h6f;
  localparam logic [7:0] OP_IN_B_IMM   = 8'he4;
  localparam logic [7:0] OP_IN_D_IMM   = 8'he5;
  localparam logic [7:0] OP_OUT_B_IMM  = 8'he6;
  localparam logic [7:0] OP_OUT_D_IMM  = 8'he7;
  localparam logic [7:0] OP_CLI        = 8'hfa;
  localparam logic [7:0] OP_STI        = 8'hfb;
  localparam logic [7:0] PFX_OPSIZE    = 8'h66;
  localparam logic [7:0] PFX_REP       = 8'hf3;

  localparam logic [SizeW-1:0] SIZE_BYTE  = 5'd0;
  localparam logic [SizeW-1:0] SIZE_WORD  = 5'd1;
  localparam logic [SizeW-1:0] SIZE_DWORD = 5'd2;

  typedef struct packed {
    logic             handled;
    logic [PortW-1:0] port_number;
    logic [SizeW-1:0] size_code;
  } dec_result_t;

endpackage

/* hdl/iopd_decode.sv */
// ----------------------------------------------------------------------------
// I/O instruction port decoder: decode logic
// Maps up to three instruction bytes to handled flag, port and size code.
// ----------------------------------------------------------------------------
module iopd_decode #(
  parameter int unsigned WHOLE_SPACE_CODE = iopd_pkg::WHOLE_SPACE_CODE_DFLT
) (
  input  logic [7:0]                    first_byte,
  input  logic [7:0]                    second_byte,
  input  logic [7:0]                    third_byte,
  input  logic [1:0]                    bytes_readable,
  input  logic [iopd_pkg::PortW-1:0]    dx_value,
  input  logic [iopd_pkg::LimitW-1:0]   port_limit,
  output iopd_pkg::dec_result_t         result
);

  logic [iopd_pkg::LimitW-1:0] dx_ext;
  logic [iopd_pkg::LimitW-1:0] b1_ext;
  logic [iopd_pkg::LimitW-1:0] b2_ext;
  logic dx_fits4;
  logic dx_fits2;
  logic b1_fits4;
  logic b2_fits2;
  logic is_opsize;
  logic is_rep;
  logic ok;
  logic [iopd_pkg::PortW-1:0] port;
  logic [iopd_pkg::SizeW-1:0] size;

  assign dx_ext   = {1'b0, dx_value};
  assign b1_ext   = {9'd0, second_byte};
  assign b2_ext   = {9'd0, third_byte};
  assign dx_fits4 = (dx_ext + 17'd4) <= port_limit;
  assign dx_fits2 = (dx_ext + 17'd2) <= port_limit;
  assign b1_fits4 = (b1_ext + 17'd4) <= port_limit;
  assign b2_fits2 = (b2_ext + 17'd2) <= port_limit;
  assign is_opsize = first_byte == iopd_pkg::PFX_OPSIZE;
  assign is_rep    = first_byte == iopd_pkg::PFX_REP;

  always_comb begin
    ok   = 1'b0;
    port = dx_value;
    size = iopd_pkg::SIZE_BYTE;
    priority if (first_byte == iopd_pkg::OP_IN_B_DX || first_byte == iopd_pkg::OP_INS_B ||
                 first_byte == iopd_pkg::OP_OUT_B_DX || first_byte == iopd_pkg::OP_OUTS_B) begin
      ok = 1'b1;
    end else if (first_byte == iopd_pkg::OP_IN_D_DX || first_byte == iopd_pkg::OP_INS_D ||
                 first_byte == iopd_pkg::OP_OUT_D_DX || first_byte == iopd_pkg::OP_OUTS_D) begin
      ok   = dx_fits4;
      size = iopd_pkg::SIZE_DWORD;
    end else if (first_byte == iopd_pkg::OP_CLI || first_byte == iopd_pkg::OP_STI) begin
      ok   = 1'b1;
      port = '0;
      size = iopd_pkg::SizeW'(WHOLE_SPACE_CODE);
    end else if (bytes_readable < 2'd2) begin
      ok = 1'b0;
    end else if (first_byte == iopd_pkg::OP_IN_B_IMM ||
                 first_byte == iopd_pkg::OP_OUT_B_IMM) begin
      ok   = 1'b1;
      port = {8'd0, second_byte};
    end else if (first_byte == iopd_pkg::OP_IN_D_IMM ||
                 first_byte == iopd_pkg::OP_OUT_D_IMM) begin
      ok   = b1_fits4;
      port = {8'd0, second_byte};
      size = iopd_pkg::SIZE_DWORD;
    end else if (is_opsize && (second_byte == iopd_pkg::OP_IN_D_DX ||
                 second_byte == iopd_pkg::OP_OUT_D_DX || second_byte == iopd_pkg::OP_INS_D ||
                 second_byte == iopd_pkg::OP_OUTS_D)) begin
      ok   = dx_fits2;
      size = iopd_pkg::SIZE_WORD;
    end else if (is_opsize && (second_byte == iopd_pkg::OP_IN_D_IMM ||
                 second_byte == iopd_pkg::OP_OUT_D_IMM)) begin
      ok   = b2_fits2;
      port = {8'd0, third_byte};
      size = iopd_pkg::SIZE_WORD;
    end else if ((is_opsize || is_rep) && (second_byte == iopd_pkg::OP_INS_B ||
                 second_byte == iopd_pkg::OP_OUTS_B)) begin
      ok = 1'b1;
    end else if ((is_opsize || is_rep) && (second_byte == iopd_pkg::OP_INS_D ||
                 second_byte == iopd_pkg::OP_OUTS_D)) begin
      ok   = dx_fits4;
      size = iopd_pkg::SIZE_DWORD;
    end else if (bytes_readable < 2'd3) begin
      ok = 1'b0;
    end else if (((is_rep && second_byte == iopd_pkg::PFX_OPSIZE) ||
                  (is_opsize && second_byte == iopd_pkg::PFX_REP)) &&
                 (third_byte == iopd_pkg::OP_INS_D || third_byte == iopd_pkg::OP_OUTS_D)) begin
      ok   = dx_fits2;
      size = iopd_pkg::SIZE_WORD;
    end else begin
      ok = 1'b0;
    end
  end

  assign result.handled     = ok;
  assign result.port_number = ok ? port : '0;
  assign result.size_code   = ok ? size : '0;

endmodule

/* hdl/io_instruction_port_decoder_top.sv */
// ----------------------------------------------------------------------------
// I/O instruction port decoder, top level
// Registers each instruction beat, decodes it and registers the result.
// ----------------------------------------------------------------------------
//   Channel  Handshake        Ports
//   input    start && !busy   in_first_byte, in_second_byte, in_third_byte,
//                             in_bytes_readable, in_dx_value
//   result   out_valid        out_handled, out_port_number, out_size_code
//   config   cfg_we           cfg_wdata (port limit)
//
// One beat is accepted every cycle; busy is always low.
// Each result passes the input register, one decode stage and the result
// register before it appears.
// Synchronous reset clears the valid bits and sets the port limit to 65536.
// The receiver cannot stall; each result is shown for exactly one cycle.
module io_instruction_port_decoder_top #(
  parameter int unsigned WHOLE_SPACE_CODE = iopd_pkg::WHOLE_SPACE_CODE_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    in_first_byte,
  input  logic [7:0]                    in_second_byte,
  input  logic [7:0]                    in_third_byte,
  input  logic [1:0]                    in_bytes_readable,
  input  logic [iopd_pkg::PortW-1:0]    in_dx_value,
  output logic                          out_valid,
  output logic                          out_handled,
  output logic [iopd_pkg::PortW-1:0]    out_port_number,
  output logic [iopd_pkg::SizeW-1:0]    out_size_code,
  input  logic                          cfg_we,
  input  logic [iopd_pkg::LimitW-1:0]   cfg_wdata
);

  logic                        in_valid_r;
  logic [7:0]                  b0_r;
  logic [7:0]                  b1_r;
  logic [7:0]                  b2_r;
  logic [1:0]                  avail_r;
  logic [iopd_pkg::PortW-1:0]  dx_r;
  logic [iopd_pkg::LimitW-1:0] port_limit_r;
  logic                        out_valid_r;
  iopd_pkg::dec_result_t       res_r;
  iopd_pkg::dec_result_t       res_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      port_limit_r <= iopd_pkg::PORT_LIMIT_RST;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
      if (cfg_we) begin
        port_limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      b0_r    <= in_first_byte;
      b1_r    <= in_second_byte;
      b2_r    <= in_third_byte;
      avail_r <= in_bytes_readable;
      dx_r    <= in_dx_value;
    end
    if (in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  iopd_decode #(
    .WHOLE_SPACE_CODE (WHOLE_SPACE_CODE)
  ) u_decode (
    .first_byte     (b0_r),
    .second_byte    (b1_r),
    .third_byte     (b2_r),
    .bytes_readable (avail_r),
    .dx_value       (dx_r),
    .port_limit     (port_limit_r),
    .result         (res_nxt)
  );

  assign out_valid       = out_valid_r;
  assign out_handled     = res_r.handled;
  assign out_port_number = res_r.port_number;
  assign out_size_code   = res_r.size_code;

endmodule

/* dv/io_instruction_port_decoder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I/O instruction port decoder testbench
// Sends port I/O instruction beats through the command handshake, predicts
// each decode result, and compares the results in order. The port limit is
// changed between phases while the pipeline is empty, with random sender
// gaps, no-gap stretches and a full drain in every phase.
// ----------------------------------------------------------------------------
module io_instruction_port_decoder_top_tb;
  import iopd_pkg::*;

  localparam int unsigned WHOLE_SPACE      = WHOLE_SPACE_CODE_DFLT;
  localparam int unsigned ITEMS_PER_PHASE  = 135;
  localparam int unsigned NUM_PHASES       = 10;
  localparam int unsigned WATCHDOG_LIMIT   = 300;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned MAX_REPORTS      = 10;

  typedef struct packed {
    logic [7:0]       first_byte;
    logic [7:0]       second_byte;
    logic [7:0]       third_byte;
    logic [1:0]       bytes_readable;
    logic [PortW-1:0] dx_value;
  } instr_t;

  localparam logic [7:0] DX_OPS [10] = '{OP_IN_B_DX, OP_IN_D_DX, OP_OUT_B_DX, OP_OUT_D_DX,
                                        OP_INS_B, OP_INS_D, OP_OUTS_B, OP_OUTS_D,
                                        OP_CLI, OP_STI};
  localparam logic [7:0] IMM_OPS [4] = '{OP_IN_B_IMM, OP_IN_D_IMM, OP_OUT_B_IMM, OP_OUT_D_IMM};
  localparam logic [7:0] OPSIZE_OPS [8] = '{OP_IN_D_DX, OP_OUT_D_DX, OP_INS_D, OP_OUTS_D,
                                           OP_IN_D_IMM, OP_OUT_D_IMM, OP_INS_B, OP_OUTS_B};
  localparam logic [7:0] STRING_OPS [4] = '{OP_INS_B, OP_INS_D, OP_OUTS_B, OP_OUTS_D};

  class decode_scoreboard;
    dec_result_t expected_decodes[$];
    int unsigned port_limit;
    int unsigned errors;

    function new();
      port_limit = 32'(PORT_LIMIT_RST);
      errors = 0;
    endfunction

    function void set_limit(logic [LimitW-1:0] value);
      port_limit = 32'(value);
    endfunction

    function int unsigned pending();
      return expected_decodes.size();
    endfunction

    function bit fits(int unsigned port, int unsigned count);
      return port + count <= port_limit;
    endfunction

    function dec_result_t make_result(bit ok, logic [PortW-1:0] port, logic [SizeW-1:0] size);
      dec_result_t r;
      r.handled     = ok;
      r.port_number = ok ? port : '0;
      r.size_code   = ok ? size : '0;
      return r;
    endfunction

    function dec_result_t decode_port_io(instr_t it);
      logic [PortW-1:0] dx;
      logic [PortW-1:0] imm1;
      logic [PortW-1:0] imm2;
      dx   = it.dx_value;
      imm1 = {8'h00, it.second_byte};
      imm2 = {8'h00, it.third_byte};
      case (it.first_byte)
        OP_IN_B_DX, OP_INS_B, OP_OUT_B_DX, OP_OUTS_B: return make_result(1'b1, dx, SIZE_BYTE);
        OP_IN_D_DX, OP_INS_D, OP_OUT_D_DX, OP_OUTS_D:
          return make_result(fits(32'(dx), 4), dx, SIZE_DWORD);
        OP_CLI, OP_STI: return make_result(1'b1, '0, SizeW'(WHOLE_SPACE & 'h1f));
        default: ;
      endcase
      if (it.bytes_readable < 2) return make_result(1'b0, '0, '0);
      case (it.first_byte)
        OP_IN_B_IMM, OP_OUT_B_IMM: return make_result(1'b1, imm1, SIZE_BYTE);
        OP_IN_D_IMM, OP_OUT_D_IMM: return make_result(fits(32'(imm1), 4), imm1, SIZE_DWORD);
        default: ;
      endcase
      if (it.first_byte == PFX_OPSIZE) begin
        case (it.second_byte)
          OP_IN_D_DX, OP_OUT_D_DX, OP_INS_D, OP_OUTS_D:
            return make_result(fits(32'(dx), 2), dx, SIZE_WORD);
          OP_IN_D_IMM, OP_OUT_D_IMM: return make_result(fits(32'(imm2), 2), imm2, SIZE_WORD);
          default: ;
        endcase
      end
      if (it.first_byte == PFX_OPSIZE || it.first_byte == PFX_REP) begin
        case (it.second_byte)
          OP_INS_B, OP_OUTS_B: return make_result(1'b1, dx, SIZE_BYTE);
          OP_INS_D, OP_OUTS_D: return make_result(fits(32'(dx), 4), dx, SIZE_DWORD);
          default: ;
        endcase
      end
      if (it.bytes_readable < 3) return make_result(1'b0, '0, '0);
      if ((it.first_byte == PFX_REP && it.second_byte == PFX_OPSIZE) ||
          (it.first_byte == PFX_OPSIZE && it.second_byte == PFX_REP)) begin
        if (it.third_byte == OP_INS_D || it.third_byte == OP_OUTS_D)
          return make_result(fits(32'(dx), 2), dx, SIZE_WORD);
      end
      return make_result(1'b0, '0, '0);
    endfunction

    function void note_input(instr_t it);
      expected_decodes.push_back(decode_port_io(it));
    endfunction

    function void check_result(dec_result_t act);
      dec_result_t exp_r;
      if (expected_decodes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: unexpected result handled=%0b port=%h size=%0d",
                   act.handled, act.port_number, act.size_code);
        return;
      end
      exp_r = expected_decodes.pop_front();
      if (act.handled !== exp_r.handled || act.port_number !== exp_r.port_number ||
          act.size_code !== exp_r.size_code) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: exp handled=%0b port=%h size=%0d, got handled=%0b port=%h size=%0d",
                   exp_r.handled, exp_r.port_number, exp_r.size_code,
                   act.handled, act.port_number, act.size_code);
      end
    endfunction
  endclass

  logic                clk               = 1'b0;
  logic                rst_n             = 1'b0;
  logic                start             = 1'b0;
  logic                busy;
  logic [7:0]          in_first_byte     = '0;
  logic [7:0]          in_second_byte    = '0;
  logic [7:0]          in_third_byte     = '0;
  logic [1:0]          in_bytes_readable = '0;
  logic [PortW-1:0]    in_dx_value       = '0;
  logic                out_valid;
  logic                out_handled;
  logic [PortW-1:0]    out_port_number;
  logic [SizeW-1:0]    out_size_code;
  logic                cfg_we            = 1'b0;
  logic [LimitW-1:0]   cfg_wdata         = '0;

  decode_scoreboard sb = new();
  int unsigned      cur_limit = 32'(PORT_LIMIT_RST);
  int unsigned      idle_cycles = 0;
  bit               no_gap_stretch = 1'b0;

  io_instruction_port_decoder_top #(
    .WHOLE_SPACE_CODE(WHOLE_SPACE)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_first_byte     (in_first_byte),
    .in_second_byte    (in_second_byte),
    .in_third_byte     (in_third_byte),
    .in_bytes_readable (in_bytes_readable),
    .in_dx_value       (in_dx_value),
    .out_valid         (out_valid),
    .out_handled       (out_handled),
    .out_port_number   (out_port_number),
    .out_size_code     (out_size_code),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_limit(cfg_wdata);
      if (start && !busy)
        sb.note_input('{in_first_byte, in_second_byte, in_third_byte,
                        in_bytes_readable, in_dx_value});
      if (out_valid)
        sb.check_result('{out_handled, out_port_number, out_size_code});
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic instr_t mk(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                logic [1:0] avail, logic [PortW-1:0] dx);
    instr_t it;
    it = '{b0, b1, b2, avail, dx};
    return it;
  endfunction

  function automatic int unsigned clamp(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PortW-1:0] pick_port();
    case ($urandom_range(0, 3))
      0: return PortW'($urandom_range(0, 65535));
      1: return PortW'(clamp(int'(cur_limit) - int'($urandom_range(0, 6)), 65535));
      2: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      default: return PortW'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [7:0] pick_imm();
    if (cur_limit <= 262 && $urandom_range(0, 1))
      return 8'(clamp(int'(cur_limit) - int'($urandom_range(0, 6)), 255));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic instr_t random_instruction();
    instr_t it;
    it.first_byte     = 8'($urandom_range(0, 255));
    it.second_byte    = 8'($urandom_range(0, 255));
    it.third_byte     = 8'($urandom_range(0, 255));
    it.bytes_readable = ($urandom_range(0, 3) != 0) ? 2'd3 : 2'($urandom_range(0, 3));
    it.dx_value       = pick_port();
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0: it.first_byte = DX_OPS[$urandom_range(0, 9)];
        1: begin
          it.first_byte  = IMM_OPS[$urandom_range(0, 3)];
          it.second_byte = pick_imm();
        end
        2: begin
          it.first_byte  = PFX_OPSIZE;
          it.second_byte = OPSIZE_OPS[$urandom_range(0, 7)];
          it.third_byte  = pick_imm();
        end
        3: begin
          it.first_byte  = PFX_REP;
          it.second_byte = STRING_OPS[$urandom_range(0, 3)];
        end
        4: begin
          it.first_byte  = $urandom_range(0, 1) ? PFX_REP : PFX_OPSIZE;
          it.second_byte = (it.first_byte == PFX_REP) ? PFX_OPSIZE : PFX_REP;
          if ($urandom_range(0, 3) != 0) it.third_byte = STRING_OPS[$urandom_range(0, 3)];
        end
        default: it.first_byte = $urandom_range(0, 1) ? PFX_REP : PFX_OPSIZE;
      endcase
    end
    return it;
  endfunction

  task automatic send_instruction(input instr_t it, input int unsigned gap);
    start             <= 1'b1;
    in_first_byte     <= it.first_byte;
    in_second_byte    <= it.second_byte;
    in_third_byte     <= it.third_byte;
    in_bytes_readable <= it.bytes_readable;
    in_dx_value       <= it.dx_value;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_port_limit(input int unsigned value);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= LimitW'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit = value;
  endtask

  function automatic int unsigned draw_gap();
    return no_gap_stretch ? 0 : $urandom_range(0, 11);
  endfunction

  initial begin
    int unsigned phase_limits [NUM_PHASES];
    phase_limits = '{65536, 0, 1, 4, 65535, 65532, 256, 3, 0, 65536};
    phase_limits[8] = $urandom_range(0, 65536);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_instruction(mk(OP_IN_B_DX, 8'h00, 8'h00, 2'd1, 16'hffff), draw_gap());
    send_instruction(mk(OP_IN_D_DX, 8'hff, 8'hff, 2'd1, 16'hfffc), draw_gap());
    send_instruction(mk(OP_OUT_D_DX, 8'h00, 8'h00, 2'd1, 16'hfffd), draw_gap());
    send_instruction(mk(OP_INS_B, 8'h00, 8'h00, 2'd0, 16'h0000), draw_gap());
    send_instruction(mk(OP_OUTS_D, 8'h00, 8'h00, 2'd0, 16'h1234), draw_gap());
    send_instruction(mk(OP_CLI, 8'hff, 8'hff, 2'd3, 16'hffff), draw_gap());
    send_instruction(mk(OP_STI, 8'h00, 8'h00, 2'd0, 16'h5555), draw_gap());
    send_instruction(mk(OP_IN_B_IMM, 8'hff, 8'h00, 2'd2, 16'h0000), draw_gap());
    send_instruction(mk(OP_OUT_B_IMM, 8'h12, 8'h00, 2'd1, 16'h0000), draw_gap());
    send_instruction(mk(OP_IN_D_IMM, 8'hfc, 8'h00, 2'd2, 16'h0000), draw_gap());
    send_instruction(mk(OP_OUT_D_IMM, 8'h00, 8'h00, 2'd3, 16'haaaa), draw_gap());
    send_instruction(mk(PFX_OPSIZE, OP_IN_D_DX, 8'h00, 2'd2, 16'hfffe), draw_gap());
    send_instruction(mk(PFX_OPSIZE, OP_OUT_D_DX, 8'h00, 2'd2, 16'hffff), draw_gap());
    send_instruction(mk(PFX_OPSIZE, OP_IN_D_IMM, 8'hff, 2'd2, 16'h0000), draw_gap());
    send_instruction(mk(PFX_OPSIZE, OP_OUT_D_IMM, 8'h10, 2'd1, 16'h0000), draw_gap());
    send_instruction(mk(PFX_OPSIZE, OP_INS_B, 8'h00, 2'd2, 16'h0abc), draw_gap());
    send_instruction(mk(PFX_OPSIZE, OP_OUTS_B, 8'h00, 2'd3, 16'hffff), draw_gap());
    send_instruction(mk(PFX_REP, OP_INS_D, 8'h00, 2'd2, 16'hfffd), draw_gap());
    send_instruction(mk(PFX_REP, OP_OUTS_B, 8'h00, 2'd2, 16'h8000), draw_gap());
    send_instruction(mk(PFX_REP, PFX_OPSIZE, OP_INS_D, 2'd3, 16'hfffe), draw_gap());
    send_instruction(mk(PFX_OPSIZE, PFX_REP, OP_OUTS_D, 2'd3, 16'hffff), draw_gap());
    send_instruction(mk(PFX_REP, PFX_OPSIZE, OP_OUTS_D, 2'd2, 16'h0001), draw_gap());
    send_instruction(mk(PFX_OPSIZE, PFX_REP, OP_INS_B, 2'd3, 16'h0001), draw_gap());
    send_instruction(mk(8'h00, 8'h00, 8'h00, 2'd3, 16'h0000), draw_gap());
    send_instruction(mk(8'hff, 8'hff, 8'hff, 2'd3, 16'hffff), draw_gap());

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      write_port_limit(phase_limits[p]);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) no_gap_stretch = ($urandom_range(0, 2) == 0);
        if (n == ITEMS_PER_PHASE / 2) wait_idle();
        send_instruction(random_instruction(), draw_gap());
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.errors += sb.pending();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* io_instruction_port_decoder_top.f */
hdl/iopd_pkg.sv
hdl/iopd_decode.sv
hdl/io_instruction_port_decoder_top.sv
dv/io_instruction_port_decoder_top_tb.sv
